FILE: src/isdr_pkg.sv
// ----------------------------------------------------------------------------
// isdr_pkg
// Shared types and constants of the inverted serial receive deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package isdr_pkg;

    // Largest packet length limit; at most LEN_MAX-1 data bytes per packet.
    localparam int LEN_MAX = 4096;
    localparam int LIM_W   = 13;
    localparam int CNT_W   = 12;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_BIT_TICKS  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RX_MODE    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_CODE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_END_CODE   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_LEN_LIMIT  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_COOLDOWN   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT    = 3'd6;

    typedef enum logic [2:0] {
        EV_DATA      = 3'd0,
        EV_END_CODE  = 3'd1,
        EV_END_LIMIT = 3'd2,
        EV_BAD_START = 3'd3,
        EV_CONTROL   = 3'd4,
        EV_TIMEOUT   = 3'd5
    } t_evt_kind;

    typedef struct packed {
        logic [15:0]      bit_ticks;
        logic             rx_mode;
        logic [7:0]       start_code;
        logic [7:0]       end_code;
        logic [LIM_W-1:0] length_limit;
        logic [23:0]      cooldown_ticks;
        logic [31:0]      timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic             valid;
        t_evt_kind        kind;
        logic [7:0]       data;
        logic [CNT_W-1:0] count;
    } t_evt;

endpackage

`default_nettype wire

FILE: src/inverted_serial_rx_deframer_unit.sv
// ----------------------------------------------------------------------------
// inverted_serial_rx_deframer_unit
// Inverted 8-bit serial receiver with start/end code packet deframing.
// Path: a sample request passes through the input register, then the state
// update into the output register; a stalled output holds it in the input register.
// Throughput: one line sample per cycle; the input register drains whenever
// the output register is empty or being taken.
// Reset: synchronous active low; hunting, packet idle, counters zero, config
// registers at their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module inverted_serial_rx_deframer_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [isdr_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [isdr_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                            s_axis_tvalid,
    output      logic                            s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,  // [0] line_level
    output      logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output      logic [23:0]                     m_axis_tdata,  // [7:0] data_byte, [19:8] byte_count
    output      logic [2:0]                      m_axis_tuser   // [2:0] event_kind
);
    import isdr_pkg::*;

    t_cfg             cfg;
    t_evt             evt;
    logic             r_in_valid;
    logic             r_in_line;
    logic             r_out_valid;
    t_evt_kind        r_out_kind;
    logic [7:0]       r_out_data;
    logic [CNT_W-1:0] r_out_count;
    logic             proc_fire;

    isdr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_addr  (i_cfg_addr),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    assign proc_fire     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || proc_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_line <= s_axis_tdata[0];
        end
    end

    isdr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (proc_fire),
        .i_line  (r_in_line),
        .i_cfg   (cfg),
        .o_evt   (evt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire) begin
            r_out_valid <= evt.valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (proc_fire && evt.valid) begin
            r_out_kind  <= evt.kind;
            r_out_data  <= evt.data;
            r_out_count <= evt.count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_count, r_out_data};
    assign m_axis_tuser  = r_out_kind;

    // a stalled result with a pending sample must hold the input side
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while pending sample cannot drain");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != EV_DATA && m_axis_tuser != EV_CONTROL)
        |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("nonzero data byte on a non-data event");

    a_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == EV_BAD_START || m_axis_tuser == EV_CONTROL ||
                           m_axis_tuser == EV_TIMEOUT))
        |-> (m_axis_tdata[19:8] == '0))
        else $error("nonzero count on a bad start, control or timeout event");

endmodule

`default_nettype wire

FILE: src/isdr_cfg.sv
// ----------------------------------------------------------------------------
// isdr_cfg
// Configuration register file, write only, reset to the documented defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module isdr_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_we,
    input  wire logic [isdr_pkg::CFG_ADDR_W-1:0] i_addr,
    input  wire logic [isdr_pkg::CFG_DATA_W-1:0] i_wdata,
    output isdr_pkg::t_cfg                       o_cfg
);
    import isdr_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_ticks      <= 16'd100;
            r_cfg.rx_mode        <= 1'b0;
            r_cfg.start_code     <= 8'd2;
            r_cfg.end_code       <= 8'd3;
            r_cfg.length_limit   <= 13'd256;
            r_cfg.cooldown_ticks <= 24'd0;
            r_cfg.timeout_ticks  <= 32'd1000000;
        end else if (i_we) begin
            case (i_addr)
                CFG_BIT_TICKS:  r_cfg.bit_ticks      <= i_wdata[15:0];
                CFG_RX_MODE:    r_cfg.rx_mode        <= i_wdata[0];
                CFG_START_CODE: r_cfg.start_code     <= i_wdata[7:0];
                CFG_END_CODE:   r_cfg.end_code       <= i_wdata[7:0];
                CFG_LEN_LIMIT:  r_cfg.length_limit   <= i_wdata[LIM_W-1:0];
                CFG_COOLDOWN:   r_cfg.cooldown_ticks <= i_wdata[23:0];
                CFG_TIMEOUT:    r_cfg.timeout_ticks  <= i_wdata[31:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: src/isdr_core.sv
// ----------------------------------------------------------------------------
// isdr_core
// Per-sample receiver and deframer state update; one sample per request.
// ----------------------------------------------------------------------------
`default_nettype none

module isdr_core (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_fire,
    input  wire logic     i_line,
    input  wire isdr_pkg::t_cfg i_cfg,
    output isdr_pkg::t_evt o_evt
);
    import isdr_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT      = 2'd0,
        PH_FRAME     = 2'd1,
        PH_FRAME_BAD = 2'd2,
        PH_COOL      = 2'd3
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [15:0]      r_tick, n_tick;
    logic [3:0]       r_bit, n_bit;
    logic [7:0]       r_shift, n_shift;
    logic             r_pkt, n_pkt;
    logic [CNT_W-1:0] r_count, n_count;
    logic [31:0]      r_wait, n_wait;

    logic [15:0]      half;
    logic [LIM_W-1:0] cap;
    logic [2:0]       bit_sel;
    t_evt             evt;

    assign half    = i_cfg.bit_ticks >> 1;

    always_comb begin
        if (i_cfg.length_limit == '0) begin
            cap = LIM_W'(1);
        end else if (i_cfg.length_limit > LIM_W'(LEN_MAX)) begin
            cap = LIM_W'(LEN_MAX);
        end else begin
            cap = i_cfg.length_limit;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_pkt   = r_pkt;
        n_count = r_count;
        n_wait  = r_wait;
        bit_sel = '0;
        evt     = '{valid: 1'b0, kind: EV_DATA, data: 8'd0, count: '0};

        case (r_phase)
            PH_HUNT: begin
                if (i_line) begin
                    n_phase = PH_FRAME;
                    n_tick  = '0;
                    n_bit   = '0;
                    n_shift = '0;
                    n_wait  = '0;
                end else if (i_cfg.rx_mode) begin
                    if (r_wait == i_cfg.timeout_ticks) begin
                        evt.valid = 1'b1;
                        evt.kind  = EV_TIMEOUT;
                        n_wait    = '0;
                    end else begin
                        n_wait = r_wait + 32'd1;
                    end
                end
            end
            PH_COOL: begin
                if (r_wait != '0) begin
                    n_wait = r_wait - 32'd1;
                end
                if (n_wait == '0) begin
                    n_phase = PH_HUNT;
                end
            end
            PH_FRAME, PH_FRAME_BAD: begin
                n_tick = r_tick + 16'd1;
                if (n_tick >= i_cfg.bit_ticks) begin
                    n_tick = '0;
                    n_bit  = r_bit + 4'd1;
                end
                // mid-bit sample of data bits 1..8 (line low reads as one)
                if (n_bit >= 4'd1 && n_bit <= 4'd8 && n_tick == half) begin
                    if (!i_line) begin
                        bit_sel          = n_bit[2:0] - 3'd1;
                        n_shift[bit_sel] = 1'b1;
                    end
                    if (n_bit == 4'd8 && r_phase == PH_FRAME) begin
                        if (i_cfg.rx_mode) begin
                            evt.valid = 1'b1;
                            evt.kind  = EV_CONTROL;
                            evt.data  = n_shift;
                        end else if (!r_pkt) begin
                            if (n_shift == i_cfg.start_code) begin
                                n_pkt   = 1'b1;
                                n_count = '0;
                            end else begin
                                evt.valid = 1'b1;
                                evt.kind  = EV_BAD_START;
                                n_phase   = PH_FRAME_BAD;
                            end
                        end else if (n_shift == i_cfg.end_code) begin
                            evt.valid = 1'b1;
                            evt.kind  = EV_END_CODE;
                            evt.count = r_count;
                            n_pkt     = 1'b0;
                        end else begin
                            evt.valid = 1'b1;
                            evt.kind  = EV_DATA;
                            evt.data  = n_shift;
                            evt.count = r_count;
                            n_count   = r_count + CNT_W'(1);
                        end
                    end
                end
                // last tick of the stop slot
                if (n_bit >= 4'd9 && ({1'b0, n_tick} + 17'd1) >= {1'b0, i_cfg.bit_ticks}) begin
                    if (n_phase == PH_FRAME_BAD) begin
                        if (i_cfg.cooldown_ticks != '0) begin
                            n_phase = PH_COOL;
                            n_wait  = {8'd0, i_cfg.cooldown_ticks};
                        end else begin
                            n_phase = PH_HUNT;
                        end
                    end else begin
                        n_phase = PH_HUNT;
                        if (!i_cfg.rx_mode && n_pkt &&
                            ({1'b0, n_count} + LIM_W'(1)) >= cap) begin
                            evt.valid = 1'b1;
                            evt.kind  = EV_END_LIMIT;
                            evt.data  = 8'd0;
                            evt.count = n_count;
                            n_pkt     = 1'b0;
                        end
                    end
                    n_tick = '0;
                    n_bit  = '0;
                end
            end
            default: n_phase = PH_HUNT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_tick  <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_pkt   <= 1'b0;
            r_count <= '0;
            r_wait  <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_pkt   <= n_pkt;
            r_count <= n_count;
            r_wait  <= n_wait;
        end
    end

    assign o_evt = evt;

endmodule

`default_nettype wire
